// ===== rtl/root_counter_timer_core_assert.svh =====
// Assertion macros for the root counter timer block.
// The enclosing module must have clk and rst_n in scope; no other dependencies.
`ifndef ROOT_COUNTER_TIMER_CORE_ASSERT_SVH
`define ROOT_COUNTER_TIMER_CORE_ASSERT_SVH

`ifndef SYNTH
`define RCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RCT_ASSERT(lbl, prop, msg)
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/rct_pkg.sv =====
// Shared types and constants for the root counter timer block.
// No dependencies; the core, input-stage and core-logic modules use it by scoped names.
package rct_pkg;

    localparam int unsigned TIMER_INDEX = 0;
    localparam logic [15:0] SCANLINE_CYCLES = 16'd3413;
    localparam logic [3:0] DOT_DIVISOR_RESET = 4'd10;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        FUNC_TICK         = 3'd0,
        FUNC_READ         = 3'd1,
        FUNC_WRITE        = 3'd2,
        FUNC_HBLANK_START = 3'd3,
        FUNC_HBLANK_END   = 3'd4,
        FUNC_VBLANK_START = 3'd5,
        FUNC_VBLANK_END   = 3'd6
    } func_t;

    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;

    localparam logic [1:0] SYNC_PAUSE     = 2'd0;
    localparam logic [1:0] SYNC_RESET     = 2'd1;
    localparam logic [1:0] SYNC_RESET_RUN = 2'd2;
    localparam logic [1:0] SYNC_WAIT      = 2'd3;

    localparam int unsigned MODE_SYNC_EN    = 0;
    localparam int unsigned MODE_RESET_TGT  = 3;
    localparam int unsigned MODE_IRQ_TGT    = 4;
    localparam int unsigned MODE_IRQ_OVF    = 5;
    localparam int unsigned MODE_IRQ_REPEAT = 6;
    localparam int unsigned MODE_IRQ_TOGGLE = 7;
    localparam int unsigned MODE_IRQ_BIT    = 10;
    localparam int unsigned MODE_TGT_FLAG   = 11;
    localparam int unsigned MODE_OVF_FLAG   = 12;

    typedef logic [12:0] mode_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  reg_select;
        logic [15:0] write_data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

// ===== rtl/rct_in_if.sv =====
// Input channel for the root counter timer: valid/ready handshake and item fields.
// No dependencies.
interface rct_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [1:0]  reg_select;
    logic [15:0] write_data;

    modport source (output valid, func, reg_select, write_data, input ready);
    modport sink (input valid, func, reg_select, write_data, output ready);
endinterface

// ===== rtl/rct_out_if.sv =====
// Result channel for the root counter timer: valid/ready handshake and result fields.
// No dependencies.
interface rct_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        irq_request;
    logic        counter_running;

    modport source (output valid, read_data, irq_request, counter_running, input ready);
    modport sink (input valid, read_data, irq_request, counter_running, output ready);
endinterface

// ===== rtl/root_counter_timer_core.sv =====
// An item passes the input register, then the result register, before its result transfer;
// one item per cycle is sustained while results are taken, the counter state loop closing inside the core.
// Throughput is one item per clock while the result side is ready.
// Reset: asynchronous and active low; counter state clears to zero and the dot divisor
// returns to ten, with both channels empty.
`include "root_counter_timer_core_assert.svh"

module root_counter_timer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    rct_in_if.sink     items,
    rct_out_if.source  results
);

    rct_pkg::stage_t stage;
    logic            advance;

    rct_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .advance (advance),
        .stage   (stage)
    );

    rct_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stage     (stage),
        .advance   (advance),
        .results   (results)
    );

    `RCT_ASSERT(a_irq_only_on_tick, !(results.valid && results.irq_request) || (results.read_data == 16'd0), "interrupt request on a result carrying read data")
    `RCT_ASSERT(a_stall_blocks_input, !(stage.valid && !advance) || !items.ready, "input accepted while the input register is stalled")
    `RCT_ASSERT_NEXT(a_advance_gives_result, advance, results.valid, "processed item did not produce a result")

endmodule

// ===== rtl/rct_in_stage.sv =====
// Input register of the root counter timer: captures one item per transfer.
// Depends on rct_pkg and rct_in_if.
module rct_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    rct_in_if.sink          items,
    input  logic            advance,
    output rct_pkg::stage_t stage
);

    logic           valid_reg;
    logic           valid_next;
    rct_pkg::item_t item_reg;

    assign items.ready = !valid_reg || advance;
    assign valid_next  = items.ready ? items.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_reg <= '{func: items.func, reg_select: items.reg_select,
                          write_data: items.write_data};
        end
    end

    assign stage = '{valid: valid_reg, item: item_reg};

endmodule

// ===== rtl/rct_core.sv =====
// Counter state, prescaler, sync and interrupt logic with the result register.
// Depends on rct_pkg and rct_out_if.
module rct_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_wdata,
    input  rct_pkg::stage_t stage,
    output logic            advance,
    rct_out_if.source       results
);

    typedef struct packed {
        rct_pkg::mode_t mode;
        logic           oneshot;
        logic           irq;
    } fire_t;

    function automatic logic eval_stopped(rct_pkg::mode_t mode, logic hb, logic vb);
        logic [1:0] sm;
        logic       blank;
        logic       st;
        sm    = mode[2:1];
        blank = (rct_pkg::TIMER_INDEX == 0) ? hb : vb;
        st    = 1'b0;
        if (mode[rct_pkg::MODE_SYNC_EN])
        begin
            if (rct_pkg::TIMER_INDEX == 2)
            begin
                st = (sm == rct_pkg::SYNC_PAUSE) || (sm == rct_pkg::SYNC_WAIT);
            end
            else
            begin
                st = ((sm == rct_pkg::SYNC_PAUSE) && blank)
                    || ((sm == rct_pkg::SYNC_RESET_RUN) && !blank)
                    || (sm == rct_pkg::SYNC_WAIT);
            end
        end
        return st;
    endfunction

    function automatic fire_t fire(fire_t s, logic is_ovf);
        fire_t r;
        logic  en;
        r = s;
        if (is_ovf)
        begin
            r.mode[rct_pkg::MODE_OVF_FLAG] = 1'b1;
            en = r.mode[rct_pkg::MODE_IRQ_OVF];
        end
        else
        begin
            r.mode[rct_pkg::MODE_TGT_FLAG] = 1'b1;
            en = r.mode[rct_pkg::MODE_IRQ_TGT];
        end
        if (en && (r.mode[rct_pkg::MODE_IRQ_REPEAT] || !r.oneshot))
        begin
            if (!r.mode[rct_pkg::MODE_IRQ_REPEAT])
            begin
                r.oneshot = 1'b1;
            end
            if (r.mode[rct_pkg::MODE_IRQ_TOGGLE])
            begin
                r.mode[rct_pkg::MODE_IRQ_BIT] = ~r.mode[rct_pkg::MODE_IRQ_BIT];
            end
            else
            begin
                r.mode[rct_pkg::MODE_IRQ_BIT] = 1'b0;
            end
            if (!r.mode[rct_pkg::MODE_IRQ_BIT])
            begin
                r.irq = 1'b1;
            end
        end
        return r;
    endfunction

    logic [15:0]    count_reg, count_next;
    logic [15:0]    prescale_reg, prescale_next;
    logic [15:0]    target_reg, target_next;
    rct_pkg::mode_t mode_reg, mode_next;
    logic           oneshot_reg, oneshot_next;
    logic           hblank_reg, hblank_next;
    logic           vblank_reg, vblank_next;
    logic [3:0]     dot_reg;
    logic           res_valid_reg, res_valid_next;
    logic [15:0]    read_data_reg, read_data_next;
    logic           irq_reg, irq_next;
    logic           running_reg, running_next;

    logic [15:0] divisor;
    logic [15:0] prescale_inc;
    logic [15:0] count_inc;
    logic        stopped_now;
    fire_t       fire_a, fire_b;

    assign advance = stage.valid && (!res_valid_reg || results.ready);

    always_comb
    begin
        divisor = 16'd1;
        if ((rct_pkg::TIMER_INDEX == 0) && mode_reg[8])
        begin
            divisor = (dot_reg == 4'd0) ? 16'd1 : {12'd0, dot_reg};
        end
        else if ((rct_pkg::TIMER_INDEX == 1) && mode_reg[8])
        begin
            divisor = rct_pkg::SCANLINE_CYCLES;
        end
        else if ((rct_pkg::TIMER_INDEX == 2) && mode_reg[9])
        begin
            divisor = 16'd8;
        end
    end

    assign stopped_now  = eval_stopped(mode_reg, hblank_reg, vblank_reg);
    assign prescale_inc = prescale_reg + 16'd1;
    assign count_inc    = count_reg + 16'd1;

    always_comb
    begin
        fire_a = '{mode: mode_reg, oneshot: oneshot_reg, irq: 1'b0};
        if (count_inc == target_reg)
        begin
            fire_a = fire(fire_a, 1'b0);
        end
        fire_b = fire_a;
        if (count_reg == rct_pkg::COUNT_MAX)
        begin
            fire_b = fire(fire_a, 1'b1);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        prescale_next  = prescale_reg;
        target_next    = target_reg;
        mode_next      = mode_reg;
        oneshot_next   = oneshot_reg;
        hblank_next    = hblank_reg;
        vblank_next    = vblank_reg;
        read_data_next = 16'd0;
        irq_next       = 1'b0;

        unique case (rct_pkg::func_t'(stage.item.func))
            rct_pkg::FUNC_TICK:
            begin
                if (!stopped_now)
                begin
                    if (prescale_inc < divisor)
                    begin
                        prescale_next = prescale_inc;
                    end
                    else
                    begin
                        prescale_next = 16'd0;
                        mode_next     = fire_b.mode;
                        oneshot_next  = fire_b.oneshot;
                        irq_next      = fire_b.irq;
                        if ((count_inc == target_reg) && mode_reg[rct_pkg::MODE_RESET_TGT])
                        begin
                            count_next = 16'd0;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                end
            end
            rct_pkg::FUNC_READ:
            begin
                unique case (stage.item.reg_select)
                    rct_pkg::REG_COUNT:  read_data_next = count_reg;
                    rct_pkg::REG_MODE:
                    begin
                        read_data_next = {3'd0, mode_reg};
                        mode_next[rct_pkg::MODE_TGT_FLAG] = 1'b0;
                        mode_next[rct_pkg::MODE_OVF_FLAG] = 1'b0;
                    end
                    rct_pkg::REG_TARGET: read_data_next = target_reg;
                    default:             read_data_next = 16'd0;
                endcase
            end
            rct_pkg::FUNC_WRITE:
            begin
                unique case (stage.item.reg_select)
                    rct_pkg::REG_COUNT:  count_next = stage.item.write_data;
                    rct_pkg::REG_MODE:
                    begin
                        count_next    = 16'd0;
                        prescale_next = 16'd0;
                        oneshot_next  = 1'b0;
                        mode_next     = {mode_reg[12:11], 1'b1, stage.item.write_data[9:0]};
                    end
                    rct_pkg::REG_TARGET: target_next = stage.item.write_data;
                    default:             target_next = target_reg;
                endcase
            end
            rct_pkg::FUNC_HBLANK_START:
            begin
                hblank_next = 1'b1;
                if ((rct_pkg::TIMER_INDEX == 0) && mode_reg[rct_pkg::MODE_SYNC_EN])
                begin
                    if ((mode_reg[2:1] == rct_pkg::SYNC_RESET)
                        || (mode_reg[2:1] == rct_pkg::SYNC_RESET_RUN))
                    begin
                        count_next = 16'd0;
                    end
                    else if (mode_reg[2:1] == rct_pkg::SYNC_WAIT)
                    begin
                        mode_next[rct_pkg::MODE_SYNC_EN] = 1'b0;
                    end
                end
            end
            rct_pkg::FUNC_HBLANK_END:
            begin
                hblank_next = 1'b0;
            end
            rct_pkg::FUNC_VBLANK_START:
            begin
                vblank_next = 1'b1;
                if ((rct_pkg::TIMER_INDEX == 1) && mode_reg[rct_pkg::MODE_SYNC_EN])
                begin
                    if ((mode_reg[2:1] == rct_pkg::SYNC_RESET)
                        || (mode_reg[2:1] == rct_pkg::SYNC_RESET_RUN))
                    begin
                        count_next = 16'd0;
                    end
                    else if (mode_reg[2:1] == rct_pkg::SYNC_WAIT)
                    begin
                        mode_next[rct_pkg::MODE_SYNC_EN] = 1'b0;
                    end
                end
            end
            rct_pkg::FUNC_VBLANK_END:
            begin
                vblank_next = 1'b0;
            end
            default:
            begin
                hblank_next = hblank_reg;
            end
        endcase

        running_next = !eval_stopped(mode_next, hblank_next, vblank_next);
    end

    assign res_valid_next = advance ? 1'b1 : (results.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 16'd0;
            prescale_reg  <= 16'd0;
            target_reg    <= 16'd0;
            mode_reg      <= '0;
            oneshot_reg   <= 1'b0;
            hblank_reg    <= 1'b0;
            vblank_reg    <= 1'b0;
            dot_reg       <= rct_pkg::DOT_DIVISOR_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                count_reg    <= count_next;
                target_reg   <= target_next;
                mode_reg     <= mode_next;
                oneshot_reg  <= oneshot_next;
                hblank_reg   <= hblank_next;
                vblank_reg   <= vblank_next;
            end
            if (cfg_we && (rct_pkg::TIMER_INDEX == 0) && mode_reg[8])
            begin
                prescale_reg <= 16'd0;
            end
            else if (advance)
            begin
                prescale_reg <= prescale_next;
            end
            if (cfg_we)
            begin
                dot_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
            running_reg   <= running_next;
        end
    end

    assign results.valid           = res_valid_reg;
    assign results.read_data       = read_data_reg;
    assign results.irq_request     = irq_reg;
    assign results.counter_running = running_reg;

endmodule
